// File: rtl/assert_macros.svh
// Assertion macros included by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/sdspi_pkg.sv
// Package for the SPI-mode SD host sequencer: types, codes and widths.
package sdspi_pkg;

  localparam int BlockBytes = 512;

  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_XCHG  = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_IFCOND   = 3'd2;
  localparam logic [2:0] ST_READY    = 3'd3;
  localparam logic [2:0] ST_OCR      = 3'd4;
  localparam logic [2:0] ST_BLOCKLEN = 3'd5;
  localparam logic [2:0] ST_READ     = 3'd6;
  localparam logic [2:0] ST_TOKEN    = 3'd7;

  localparam logic [1:0] CARD_NONE = 2'd0;
  localparam logic [1:0] CARD_SDSC = 2'd1;
  localparam logic [1:0] CARD_SDHC = 2'd2;

  localparam logic [5:0] SD_CMD0  = 6'd0;
  localparam logic [5:0] SD_CMD8  = 6'd8;
  localparam logic [5:0] SD_CMD16 = 6'd16;
  localparam logic [5:0] SD_CMD17 = 6'd17;
  localparam logic [5:0] SD_CMD41 = 6'd41;
  localparam logic [5:0] SD_CMD55 = 6'd55;
  localparam logic [5:0] SD_CMD58 = 6'd58;

  localparam logic [2:0] CFG_POWER = 3'd0;
  localparam logic [2:0] CFG_FLUSH = 3'd1;
  localparam logic [2:0] CFG_RESP  = 3'd2;
  localparam logic [2:0] CFG_IDLE  = 3'd3;
  localparam logic [2:0] CFG_READY = 3'd4;
  localparam logic [2:0] CFG_TOKEN = 3'd5;

  typedef enum logic [3:0] {
    PH_IDLE, PH_POWER, PH_FLUSH, PH_FRAME, PH_RESP,
    PH_PAYLOAD, PH_TOKEN, PH_DATA, PH_CRC, PH_DESELECT
  } phase_t;

  // Result item, in output field order.
  typedef struct packed {
    logic [15:0] init_count;
    logic [7:0]  last_response;
    logic [1:0]  card_kind;
    logic [2:0]  status;
    logic        done_res;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        pause_first;
    logic        fast_clock;
    logic        select_low;
    logic [7:0]  send_byte;
    logic        send_valid;
  } result_t;

endpackage

// File: rtl/sd_card_spi_host_sequencer.sv
// Top level of the SPI-mode SD host sequencer: init and single-block read.
// Each request is registered, handled by one pass of logic and its result
// is registered: out_tvalid rises when the held request moves into the result register.
// Throughput is one request per cycle while out_tready is high; the phase registers are the only loop.
// A full read is about 530 exchanges, each one request from the shifter.
// Synchronous active-low reset clears the valid flags and sequencer state and restores default limits.
module sd_card_spi_host_sequencer #(
  parameter int BLOCK_BYTES = sdspi_pkg::BlockBytes
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // command[1:0], block_address[33:2], miso_byte[41:34]
  output logic        out_tvalid,
  input  logic        out_tready,
  // send_valid, send_byte, select_low, fast_clock, pause_first, data_valid,
  // data_byte, done_res, status, card_kind, last_response, init_count
  output logic [55:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int BcW = $clog2(BLOCK_BYTES + 1);
  localparam int ShW = $clog2(BLOCK_BYTES);

  // Configuration registers.
  logic [7:0]  power_up_r, flush_lim_r, resp_win_r, idle_lim_r;
  logic [15:0] ready_lim_r, token_win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_up_r  <= 8'd10;
      flush_lim_r <= 8'd10;
      resp_win_r  <= 8'd16;
      idle_lim_r  <= 8'd8;
      ready_lim_r <= 16'd2000;
      token_win_r <= 16'd4000;
    end else if (cfg_we) begin
      case (cfg_index)
        sdspi_pkg::CFG_POWER: power_up_r  <= cfg_wdata[7:0];
        sdspi_pkg::CFG_FLUSH: flush_lim_r <= cfg_wdata[7:0];
        sdspi_pkg::CFG_RESP:  resp_win_r  <= cfg_wdata[7:0];
        sdspi_pkg::CFG_IDLE:  idle_lim_r  <= cfg_wdata[7:0];
        sdspi_pkg::CFG_READY: ready_lim_r <= cfg_wdata;
        sdspi_pkg::CFG_TOKEN: token_win_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register and result register handshake.
  logic        iv_r;
  logic [47:0] id_r;
  logic        ov_r;
  sdspi_pkg::result_t res_r, res_nxt;
  logic        adv;

  assign adv        = iv_r && (!ov_r || out_tready);
  assign in_tready  = !iv_r || adv;
  assign out_tvalid = ov_r;
  assign out_tdata  = {{(56 - $bits(sdspi_pkg::result_t)){1'b0}}, res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (in_tready) iv_r <= in_tvalid;
      if (adv) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) id_r <= in_tdata;
    if (adv) res_r <= res_nxt;
  end

  // Sequencer state.
  sdspi_pkg::phase_t phase_r, phase_nxt;
  logic [BcW-1:0] bc_r, bc_nxt;
  logic [15:0] retry_r, retry_nxt, wait_r, wait_nxt, att_r, att_nxt;
  logic [31:0] shift_r, shift_nxt, arg_r, arg_nxt;
  logic [5:0]  cidx_r, cidx_nxt;
  logic [1:0]  card_r, card_nxt;
  logic        fast_r, fast_nxt;
  logic [7:0]  resp_r, resp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sdspi_pkg::PH_IDLE;
      bc_r    <= '0;
      retry_r <= '0;
      wait_r  <= '0;
      shift_r <= '0;
      arg_r   <= '0;
      cidx_r  <= '0;
      card_r  <= sdspi_pkg::CARD_NONE;
      fast_r  <= 1'b0;
      resp_r  <= 8'hFF;
      att_r   <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      bc_r    <= bc_nxt;
      retry_r <= retry_nxt;
      wait_r  <= wait_nxt;
      shift_r <= shift_nxt;
      arg_r   <= arg_nxt;
      cidx_r  <= cidx_nxt;
      card_r  <= card_nxt;
      fast_r  <= fast_nxt;
      resp_r  <= resp_nxt;
      att_r   <= att_nxt;
    end
  end

  // Request fields.
  logic [1:0]  cmd;
  logic [31:0] lba;
  logic [7:0]  miso;
  assign cmd  = id_r[1:0];
  assign lba  = id_r[33:2];
  assign miso = id_r[41:34];

  // Frame byte for the current frame position.
  logic [7:0] frame_b;
  always_comb begin
    case (bc_r[2:0])
      3'd0: frame_b = {2'b01, cidx_r};
      3'd1: frame_b = arg_r[31:24];
      3'd2: frame_b = arg_r[23:16];
      3'd3: frame_b = arg_r[15:8];
      3'd4: frame_b = arg_r[7:0];
      default: begin
        if (cidx_r == sdspi_pkg::SD_CMD0) frame_b = 8'h95;
        else if (cidx_r == sdspi_pkg::SD_CMD8 && arg_r == 32'h1AA) frame_b = 8'h87;
        else frame_b = 8'h01;
      end
    endcase
  end

  // Next state and result.
  logic        o_send, o_pause, o_dv, o_done;
  logic [7:0]  o_byte;
  logic [2:0]  o_stat;
  logic [15:0] retry_inc;
  logic [BcW-1:0] bc_inc;
  logic [31:0] shift_new;
  logic [1:0]  new_card;

  assign retry_inc = retry_r + 16'd1;
  assign bc_inc    = bc_r + BcW'(1);
  assign shift_new = {shift_r[23:0], miso};
  assign new_card  = shift_new[30] ? sdspi_pkg::CARD_SDHC : sdspi_pkg::CARD_SDSC;

  always_comb begin
    phase_nxt = phase_r;
    bc_nxt    = bc_r;
    retry_nxt = retry_r;
    wait_nxt  = wait_r;
    shift_nxt = shift_r;
    arg_nxt   = arg_r;
    cidx_nxt  = cidx_r;
    card_nxt  = card_r;
    fast_nxt  = fast_r;
    resp_nxt  = resp_r;
    att_nxt   = att_r;
    o_send = 1'b0; o_byte = 8'h00; o_pause = 1'b0;
    o_dv = 1'b0; o_done = 1'b0; o_stat = sdspi_pkg::ST_OK;

    case (cmd)
      sdspi_pkg::CMD_INIT: begin
        if (att_r != 16'hFFFF) att_nxt = att_r + 16'd1;
        card_nxt  = sdspi_pkg::CARD_NONE;
        fast_nxt  = 1'b0;
        phase_nxt = sdspi_pkg::PH_POWER;
        bc_nxt    = BcW'(1);
        o_send = 1'b1; o_byte = 8'hFF;
      end
      sdspi_pkg::CMD_READ: begin
        if (card_r == sdspi_pkg::CARD_NONE) begin
          phase_nxt = sdspi_pkg::PH_IDLE;
          bc_nxt = '0;
          o_done = 1'b1;
          o_stat = sdspi_pkg::ST_IDLE;
        end else begin
          cidx_nxt  = sdspi_pkg::SD_CMD17;
          arg_nxt   = (card_r == sdspi_pkg::CARD_SDHC) ? lba : (lba << ShW);
          phase_nxt = sdspi_pkg::PH_FLUSH;
          wait_nxt  = 16'd1;
          o_send = 1'b1; o_byte = 8'hFF;
        end
      end
      sdspi_pkg::CMD_XCHG: begin
        case (phase_r)
          sdspi_pkg::PH_POWER: begin
            o_send = 1'b1; o_byte = 8'hFF;
            if (bc_r >= BcW'(power_up_r)) begin
              retry_nxt = '0;
              cidx_nxt = sdspi_pkg::SD_CMD0; arg_nxt = '0;
              phase_nxt = sdspi_pkg::PH_FLUSH; wait_nxt = 16'd1;
            end else bc_nxt = bc_inc;
          end
          sdspi_pkg::PH_FLUSH: begin
            o_send = 1'b1;
            if (miso == 8'hFF || wait_r >= 16'(flush_lim_r)) begin
              phase_nxt = sdspi_pkg::PH_FRAME;
              bc_nxt = BcW'(1);
              o_byte = {2'b01, cidx_r};
            end else begin
              wait_nxt = wait_r + 16'd1;
              o_byte = 8'hFF;
            end
          end
          sdspi_pkg::PH_FRAME: begin
            o_send = 1'b1;
            if (bc_r < BcW'(6)) begin
              o_byte = frame_b;
              bc_nxt = bc_inc;
            end else begin
              phase_nxt = sdspi_pkg::PH_RESP;
              wait_nxt = 16'd1;
              o_byte = 8'hFF;
            end
          end
          sdspi_pkg::PH_RESP: begin
            o_send = 1'b1; o_byte = 8'hFF;
            if (!miso[7] || wait_r >= 16'(resp_win_r)) begin
              resp_nxt = miso;
              phase_nxt = sdspi_pkg::PH_FLUSH;
              wait_nxt = 16'd1;
              case (cidx_r)
                sdspi_pkg::SD_CMD0: begin
                  if (miso == 8'h01) begin
                    cidx_nxt = sdspi_pkg::SD_CMD8; arg_nxt = 32'h1AA;
                  end else begin
                    retry_nxt = retry_inc;
                    if (retry_inc >= 16'(idle_lim_r)) begin
                      phase_nxt = sdspi_pkg::PH_DESELECT;
                      bc_nxt = BcW'(sdspi_pkg::ST_IDLE);
                    end else begin
                      cidx_nxt = sdspi_pkg::SD_CMD0; arg_nxt = '0;
                    end
                  end
                end
                sdspi_pkg::SD_CMD8: begin
                  if (miso[2]) begin
                    phase_nxt = sdspi_pkg::PH_DESELECT;
                    bc_nxt = BcW'(sdspi_pkg::ST_IFCOND);
                  end else begin
                    phase_nxt = sdspi_pkg::PH_PAYLOAD;
                    bc_nxt = BcW'(1); shift_nxt = '0;
                  end
                end
                sdspi_pkg::SD_CMD55: begin
                  cidx_nxt = sdspi_pkg::SD_CMD41; arg_nxt = 32'h4000_0000;
                end
                sdspi_pkg::SD_CMD41: begin
                  if (miso == 8'h00) begin
                    cidx_nxt = sdspi_pkg::SD_CMD58; arg_nxt = '0;
                  end else begin
                    retry_nxt = retry_inc;
                    o_pause = 1'b1;
                    if (retry_inc >= ready_lim_r) begin
                      phase_nxt = sdspi_pkg::PH_DESELECT;
                      bc_nxt = BcW'(sdspi_pkg::ST_READY);
                    end else begin
                      cidx_nxt = sdspi_pkg::SD_CMD55; arg_nxt = '0;
                    end
                  end
                end
                sdspi_pkg::SD_CMD58: begin
                  if (miso != 8'h00) begin
                    phase_nxt = sdspi_pkg::PH_DESELECT;
                    bc_nxt = BcW'(sdspi_pkg::ST_OCR);
                  end else begin
                    phase_nxt = sdspi_pkg::PH_PAYLOAD;
                    bc_nxt = BcW'(1); shift_nxt = '0;
                  end
                end
                sdspi_pkg::SD_CMD16: begin
                  phase_nxt = sdspi_pkg::PH_DESELECT;
                  bc_nxt = (miso != 8'h00) ? BcW'(sdspi_pkg::ST_BLOCKLEN)
                                           : BcW'(sdspi_pkg::ST_OK);
                end
                default: begin
                  if (miso != 8'h00) begin
                    phase_nxt = sdspi_pkg::PH_DESELECT;
                    bc_nxt = BcW'(sdspi_pkg::ST_READ);
                  end else begin
                    phase_nxt = sdspi_pkg::PH_TOKEN;
                  end
                end
              endcase
            end else wait_nxt = wait_r + 16'd1;
          end
          sdspi_pkg::PH_PAYLOAD: begin
            o_send = 1'b1; o_byte = 8'hFF;
            shift_nxt = shift_new;
            if (bc_r < BcW'(4)) bc_nxt = bc_inc;
            else if (cidx_r == sdspi_pkg::SD_CMD8) begin
              if (shift_new[11:0] != 12'h1AA) begin
                phase_nxt = sdspi_pkg::PH_DESELECT;
                bc_nxt = BcW'(sdspi_pkg::ST_IFCOND);
              end else begin
                retry_nxt = '0;
                cidx_nxt = sdspi_pkg::SD_CMD55; arg_nxt = '0;
                phase_nxt = sdspi_pkg::PH_FLUSH; wait_nxt = 16'd1;
              end
            end else begin
              card_nxt = new_card;
              if (new_card == sdspi_pkg::CARD_SDSC) begin
                cidx_nxt = sdspi_pkg::SD_CMD16; arg_nxt = 32'(BLOCK_BYTES);
                phase_nxt = sdspi_pkg::PH_FLUSH; wait_nxt = 16'd1;
              end else begin
                phase_nxt = sdspi_pkg::PH_DESELECT;
                bc_nxt = BcW'(sdspi_pkg::ST_OK);
              end
            end
          end
          sdspi_pkg::PH_TOKEN: begin
            o_send = 1'b1; o_byte = 8'hFF;
            if (miso != 8'hFF || wait_r >= token_win_r) begin
              if (miso == 8'hFE) begin
                phase_nxt = sdspi_pkg::PH_DATA;
                bc_nxt = '0;
              end else begin
                phase_nxt = sdspi_pkg::PH_DESELECT;
                bc_nxt = BcW'(sdspi_pkg::ST_TOKEN);
              end
            end else wait_nxt = wait_r + 16'd1;
          end
          sdspi_pkg::PH_DATA: begin
            o_send = 1'b1; o_byte = 8'hFF;
            o_dv = 1'b1;
            bc_nxt = bc_inc;
            if (bc_inc >= BcW'(BLOCK_BYTES)) begin
              phase_nxt = sdspi_pkg::PH_CRC;
              bc_nxt = '0;
            end
          end
          sdspi_pkg::PH_CRC: begin
            o_send = 1'b1; o_byte = 8'hFF;
            if (bc_inc < BcW'(2)) bc_nxt = bc_inc;
            else begin
              phase_nxt = sdspi_pkg::PH_DESELECT;
              bc_nxt = BcW'(sdspi_pkg::ST_OK);
            end
          end
          sdspi_pkg::PH_DESELECT: begin
            o_done = 1'b1;
            o_stat = bc_r[2:0];
            if (bc_r[2:0] == sdspi_pkg::ST_OK && cidx_r != sdspi_pkg::SD_CMD17)
              fast_nxt = 1'b1;
            phase_nxt = sdspi_pkg::PH_IDLE;
            bc_nxt = '0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Result assembly.
  always_comb begin
    res_nxt.send_valid    = o_send;
    res_nxt.send_byte     = o_byte;
    res_nxt.select_low    = o_send && phase_nxt != sdspi_pkg::PH_POWER &&
                            phase_nxt != sdspi_pkg::PH_DESELECT;
    res_nxt.fast_clock    = fast_nxt;
    res_nxt.pause_first   = o_pause && o_send;
    res_nxt.data_valid    = o_dv;
    res_nxt.data_byte     = o_dv ? miso : 8'h00;
    res_nxt.done_res      = o_done;
    res_nxt.status        = o_done ? o_stat : sdspi_pkg::ST_OK;
    res_nxt.card_kind     = card_nxt;
    res_nxt.last_response = resp_nxt;
    res_nxt.init_count    = att_nxt;
  end

endmodule

// File: rtl/sdspi_checker.sv
// Port-level checker for the SD host sequencer, bound to the top level.
`include "assert_macros.svh"
module sdspi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  `ASSERT_IMPL(a_idle_byte, clk, rst_n, out_tvalid && !out_tdata[0], out_tdata[8:1] == 8'h00)
  `ASSERT_IMPL(a_idle_sel, clk, rst_n, out_tvalid && !out_tdata[0], !out_tdata[9] && !out_tdata[11])
  `ASSERT_IMPL(a_done_nosend, clk, rst_n, out_tvalid && out_tdata[21], !out_tdata[0])
endmodule

bind sd_card_spi_host_sequencer sdspi_checker u_sdspi_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata)
);
